// ----- rtl/red_queue_admission_top_defines.svh -----
// ----------------------------------------------------------------------------
// red_queue_admission_top_defines.svh
// Assertion macros used by the queue admission checker.
// ----------------------------------------------------------------------------
`ifndef RED_QUEUE_ADMISSION_TOP_DEFINES_SVH
`define RED_QUEUE_ADMISSION_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RQA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RQA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rqa_pkg.sv -----
// ----------------------------------------------------------------------------
// rqa_pkg
// Types, status codes and register defaults of the RED queue admission block.
// ----------------------------------------------------------------------------
package rqa_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 1024;

  localparam int DESC_W   = 48;
  localparam int AVG_W    = 27;
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 17;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int DVD_W    = 43;
  localparam int DSR_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [AVG_W-1:0] AVG_MAX = '1;

  // result status codes
  localparam logic [2:0] ST_QUEUED = 3'd0;
  localparam logic [2:0] ST_LOST   = 3'd1;
  localparam logic [2:0] ST_FORCED = 3'd2;
  localparam logic [2:0] ST_RANDOM = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;
  localparam logic [2:0] ST_DEQ    = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RED_ON        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_ENABLE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_PERCENT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_WEIGHT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DROP_PROB = 3'd6;

  // register reset values
  localparam logic        RST_RED_ON        = 1'b0;
  localparam logic        RST_LOSS_ENABLE   = 1'b1;
  localparam logic [6:0]  RST_LOSS_PERCENT  = 7'd10;
  localparam logic [10:0] RST_MIN_THRESHOLD = 11'd100;
  localparam logic [10:0] RST_MAX_THRESHOLD = 11'd900;
  localparam logic [15:0] RST_AVG_WEIGHT    = 16'd131;
  localparam logic [15:0] RST_MAX_DROP_PROB = 16'd6554;

  localparam logic [6:0] RAND_SPAN = 7'd100;

  typedef struct packed {
    logic        kind;
    logic [15:0] dest_port;
    logic [31:0] frame_tag;
    logic [6:0]  loss_random;
    logic [6:0]  red_random;
  } arr_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        out_valid;
    logic [15:0] out_dest;
    logic [31:0] out_tag;
    logic [10:0] queue_level;
  } res_word_t;

endpackage

// ----- rtl/rqa_if.sv -----
// ----------------------------------------------------------------------------
// rqa_if
// Valid/ready channels of the RED queue admission block.
// ----------------------------------------------------------------------------
interface rqa_arr_if;
  import rqa_pkg::*;
  logic      valid;
  logic      ready;
  arr_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rqa_res_if;
  import rqa_pkg::*;
  logic      valid;
  logic      ready;
  res_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rqa_cfg_if;
  import rqa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface

// ----- rtl/red_queue_admission_top.sv -----
// ----------------------------------------------------------------------------
// red_queue_admission_top
// Packet queue with Random Early Detection admission and a ring FIFO.
// ----------------------------------------------------------------------------
// Each word on arr is either a packet arrival or a dequeue request and gives
// exactly one word on res. Items are handled one at a time: arr is ready only
// when the sequencer is idle and the result register is free or being taken.
// A dequeue reads the RAM, then loads the result; a lost arrival or an
// empty dequeue is answered from the idle state; a plain admission or forced
// drop makes two passes through the shared multiplier for the moving average;
// and an arrival that needs the probabilistic test also waits for the
// 43-bit restoring divider that forms the base drop probability one quotient
// bit per cycle. The descriptor store needs no clearing pass, so the block
// is ready right after reset. Configuration writes are always accepted and
// should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module red_queue_admission_top #(
  parameter int QUEUE_DEPTH = rqa_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  rqa_arr_if.sink   arr,
  rqa_res_if.source res,
  rqa_cfg_if.sink   cfg
);
  import rqa_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEQ  = 4'd1;
  localparam logic [3:0] S_PB   = 4'd2;
  localparam logic [3:0] S_PBW  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_CPA  = 4'd5;
  localparam logic [3:0] S_CPB  = 4'd6;
  localparam logic [3:0] S_CPC  = 4'd7;
  localparam logic [3:0] S_CPD  = 4'd8;
  localparam logic [3:0] S_AVA  = 4'd9;
  localparam logic [3:0] S_AVB  = 4'd10;
  localparam logic [3:0] S_AVC  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  // configuration registers
  logic        red_on;
  logic        loss_enable;
  logic [6:0]  loss_percent;
  logic [10:0] min_threshold;
  logic [10:0] max_threshold;
  logic [15:0] avg_weight;
  logic [15:0] max_drop_prob;

  // queue state
  logic [3:0]       state;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [OCC_W-1:0] occ;
  logic [AVG_W-1:0] avg;
  logic [15:0]      since_drop;
  logic [2:0]       pend;
  arr_word_t        item;

  // intermediate results of the sequencer
  logic [43:0]        p1;
  logic [DVD_W-1:0]   pb;
  logic [47:0]        cp_lo;
  logic               big;
  logic [MUL_P_W-1:0] pb100;

  logic      res_v;
  logic      res_load;
  res_word_t res_d;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_q;

  logic              ram_we;
  logic              ram_re;
  logic [DESC_W-1:0] ram_rdata;

  logic             out_free;
  logic             accept;
  logic             lost_hit;
  logic [AVG_W-1:0] lo_level;
  logic [AVG_W-1:0] hi_level;
  logic [AVG_W-1:0] avg_excess;
  logic [DSR_W-1:0] span;
  logic [OCC_W-1:0] occ_inc;
  logic [OCC_W-1:0] occ_dec;
  logic [OCC_W+16:0] occ_ext;
  logic [OCC_W+10:0] inc_ext;
  logic [OCC_W+10:0] dec_ext;
  logic [MUL_P_W-1:0] avg_sum;
  logic [MUL_P_W-17:0] avg_new;
  logic [MUL_P_W-1:0] pb_ext;
  logic               rand_drop;

  assign out_free   = !res_v || res.ready;
  assign arr.ready  = (state == S_IDLE) && out_free;
  assign accept     = arr.valid && arr.ready;
  assign cfg.ready  = 1'b1;
  assign res.valid  = res_v;
  assign res.data   = res_d;

  // simulated loss hit on the offered arrival
  assign lost_hit   = loss_enable && (arr.data.loss_random < loss_percent);

  // a result word is loaded on an empty dequeue, a loss, or at the end of a
  // dequeue or admission
  assign res_load   = (accept && (arr.data.kind ? (occ == '0) : lost_hit))
                      || (((state == S_DEQ) || (state == S_FIN)) && out_free);

  assign lo_level   = {min_threshold, 16'b0};
  assign hi_level   = {max_threshold, 16'b0};
  assign avg_excess = avg - lo_level;
  assign span       = max_threshold - min_threshold;
  assign occ_inc    = occ + 1'b1;
  assign occ_dec    = occ - 1'b1;
  assign occ_ext    = {17'b0, occ};
  assign inc_ext    = {11'b0, occ_inc};
  assign dec_ext    = {11'b0, occ_dec};

  // new average: (65536 - w) * avg + (w * occ) << 16, then drop 16 bits
  assign avg_sum = MUL_P_W'(p1) + {mul_p[MUL_P_W-17:0], 16'b0};
  assign avg_new = avg_sum[MUL_P_W-1:16];

  // 100 * pb as shifts and adds
  assign pb_ext = MUL_P_W'(pb);
  assign pb100  = (pb_ext << 6) + (pb_ext << 5) + (pb_ext << 2);

  assign rand_drop = big ? (item.red_random < RAND_SPAN) : (mul_p < pb100);

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_PB: begin
        mul_a = MUL_A_W'(avg_excess);
        mul_b = MUL_B_W'(max_drop_prob);
      end
      S_CPA: begin
        mul_a = MUL_A_W'(pb[31:0]);
        mul_b = MUL_B_W'(since_drop);
      end
      S_CPB: begin
        mul_a = MUL_A_W'(pb[DVD_W-1:32]);
        mul_b = MUL_B_W'(since_drop);
      end
      S_CPC: begin
        mul_a = {1'b1, 32'b0} - {1'b0, cp_lo[31:0]};
        mul_b = MUL_B_W'(item.red_random);
      end
      S_AVA: begin
        mul_a = MUL_A_W'(avg);
        mul_b = {1'b1, 16'b0} - {1'b0, avg_weight};
      end
      S_AVB: begin
        mul_a = MUL_A_W'(avg_weight);
        mul_b = occ_ext[16:0];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign div_start = (state == S_PBW);
  assign ram_re    = accept && arr.data.kind && (occ != '0);
  assign ram_we    = (state == S_FIN) && out_free && (pend == ST_QUEUED)
                     && (occ < OCC_FULL);

  rqa_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  rqa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_p[DVD_W-1:0]),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_q)
  );

  rqa_ram #(
    .WIDTH (DESC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata ({item.dest_port, item.frame_tag}),
    .re    (ram_re),
    .raddr (head),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      red_on        <= RST_RED_ON;
      loss_enable   <= RST_LOSS_ENABLE;
      loss_percent  <= RST_LOSS_PERCENT;
      min_threshold <= RST_MIN_THRESHOLD;
      max_threshold <= RST_MAX_THRESHOLD;
      avg_weight    <= RST_AVG_WEIGHT;
      max_drop_prob <= RST_MAX_DROP_PROB;
    end else if (cfg.valid) begin
      case (cfg.idx)
        REG_RED_ON:        red_on        <= cfg.wdata[0];
        REG_LOSS_ENABLE:   loss_enable   <= cfg.wdata[0];
        REG_LOSS_PERCENT:  loss_percent  <= cfg.wdata[6:0];
        REG_MIN_THRESHOLD: min_threshold <= cfg.wdata[10:0];
        REG_MAX_THRESHOLD: max_threshold <= cfg.wdata[10:0];
        REG_AVG_WEIGHT:    avg_weight    <= cfg.wdata;
        REG_MAX_DROP_PROB: max_drop_prob <= cfg.wdata;
        default: begin
          red_on <= red_on;
        end
      endcase
    end
  end

  // result valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (res_load) begin
      res_v <= 1'b1;
    end else if (res.ready) begin
      res_v <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      occ        <= '0;
      avg        <= '0;
      since_drop <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            item <= arr.data;
            if (arr.data.kind) begin
              if (occ != '0) begin
                state <= S_DEQ;
              end else begin
                // empty dequeue: answer at once, nothing changes
                res_d <= '{ST_DEQ, 1'b0, 16'b0, 32'b0, occ_ext[10:0]};
              end
            end else if (lost_hit) begin
              res_d <= '{ST_LOST, 1'b0, 16'b0, 32'b0, occ_ext[10:0]};
            end else if (red_on && (avg >= lo_level) && (avg >= hi_level)) begin
              pend  <= ST_FORCED;
              state <= S_AVA;
            end else if (red_on && (max_threshold > min_threshold)
                         && (avg >= lo_level)) begin
              state <= S_PB;
            end else begin
              pend  <= ST_QUEUED;
              state <= S_AVA;
            end
          end
        end
        S_DEQ: begin
          if (out_free) begin
            res_d <= '{ST_DEQ, 1'b1, ram_rdata[DESC_W-1:32], ram_rdata[31:0],
                       dec_ext[10:0]};
            head  <= (head == IDX_LAST) ? '0 : head + 1'b1;
            occ   <= occ_dec;
            state <= S_IDLE;
          end
        end
        S_PB: begin
          state <= S_PBW;
        end
        S_PBW: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            pb    <= div_q;
            state <= S_CPA;
          end
        end
        S_CPA: begin
          state <= S_CPB;
        end
        S_CPB: begin
          cp_lo <= mul_p[47:0];
          state <= S_CPC;
        end
        S_CPC: begin
          // since_drop * pb reaches 2^32: probability taken as one
          big   <= (mul_p != '0) || (cp_lo[47:32] != '0);
          state <= S_CPD;
        end
        S_CPD: begin
          pend  <= rand_drop ? ST_RANDOM : ST_QUEUED;
          state <= S_AVA;
        end
        S_AVA: begin
          state <= S_AVB;
        end
        S_AVB: begin
          p1    <= mul_p[43:0];
          state <= S_AVC;
        end
        S_AVC: begin
          avg   <= (avg_new > (MUL_P_W-16)'(AVG_MAX)) ? AVG_MAX : avg_new[AVG_W-1:0];
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
            if (pend == ST_QUEUED) begin
              if (since_drop != '1) begin
                since_drop <= since_drop + 1'b1;
              end
              if (occ < OCC_FULL) begin
                tail  <= (tail == IDX_LAST) ? '0 : tail + 1'b1;
                occ   <= occ_inc;
                res_d <= '{ST_QUEUED, 1'b0, 16'b0, 32'b0, inc_ext[10:0]};
              end else begin
                res_d <= '{ST_FULL, 1'b0, 16'b0, 32'b0, occ_ext[10:0]};
              end
            end else begin
              since_drop <= '0;
              res_d      <= '{pend, 1'b0, 16'b0, 32'b0, occ_ext[10:0]};
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ----- rtl/rqa_ram.sv -----
// ----------------------------------------------------------------------------
// rqa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rqa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/rqa_mul.sv -----
// ----------------------------------------------------------------------------
// rqa_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module rqa_mul (
  input  logic                         clk,
  input  logic [rqa_pkg::MUL_A_W-1:0] a,
  input  logic [rqa_pkg::MUL_B_W-1:0] b,
  output logic [rqa_pkg::MUL_P_W-1:0] p
);
  import rqa_pkg::*;

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end
endmodule

// ----- rtl/rqa_div.sv -----
// ----------------------------------------------------------------------------
// rqa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rqa_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rqa_pkg::DVD_W-1:0] dividend,
  input  logic [rqa_pkg::DSR_W-1:0] divisor,
  output logic                       done,
  output logic [rqa_pkg::DVD_W-1:0] quotient
);
  import rqa_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W:0]   trial;
  logic             fits;

  // shift one dividend bit into the partial remainder
  assign trial = {rem, dvd[DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? DSR_W'(trial - {1'b0, dsr}) : trial[DSR_W-1:0];
      dvd <= {dvd[DVD_W-2:0], fits};
    end
  end
endmodule

// ----- rtl/rqa_checker.sv -----
// ----------------------------------------------------------------------------
// rqa_checker
// Port-level checks of the RED queue admission block, bound to the top.
// ----------------------------------------------------------------------------
`include "red_queue_admission_top_defines.svh"

module rqa_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  status,
  input logic        out_valid,
  input logic [15:0] out_dest,
  input logic [31:0] out_tag
);
  import rqa_pkg::*;

  `RQA_ASSERT_IMP(a_status_code, clk, rst, res_valid, (status <= ST_DEQ), "bad status code")
  `RQA_ASSERT_IMP(a_valid_on_deq, clk, rst, res_valid && out_valid, (status == ST_DEQ), "packet without dequeue")
  `RQA_ASSERT_IMP(a_empty_zero, clk, rst, res_valid && !out_valid, (out_dest == '0) && (out_tag == '0), "nonzero descriptor")
  `RQA_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(status), "result word dropped")
endmodule

bind red_queue_admission_top rqa_checker u_rqa_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .status    (res.data.status),
  .out_valid (res.data.out_valid),
  .out_dest  (res.data.out_dest),
  .out_tag   (res.data.out_tag)
);
